### rtl/assert_macros.svh
// assertion helpers for the lcs engine
// define NO_ASSERTIONS to compile them away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lcs assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("lcs forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// shared constants and command codes of the lcs length engine
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int MAX_LEN_DEF = 256;
    localparam int SYM_W       = 8;
    localparam int LEN_W       = 9;
    localparam int CMD_W       = 2;
    localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_SWEEP  = 2'd1,
        CMD_REPORT = 2'd2
    } t_cmd;

endpackage

### rtl/lcs_ram.sv
// ----------------------------------------------------------------------------
// lcs_ram
// simple dual port synchronous memory, one write and one registered read
// ----------------------------------------------------------------------------
module lcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/lcs_length_engine_core.sv
// ----------------------------------------------------------------------------
// lcs_length_engine_core
// longest common subsequence length over a stored first string
// ----------------------------------------------------------------------------
// usage:
//   a command is transferred when start is high and busy is low.
//   append (code 0) stores i_symbol as the next first-string byte;
//   bytes past MAX_LEN are dropped and set the overflow flag.
//   sweep (code 1) runs i_symbol across the stored string: one row entry
//   is read, updated and written back per cycle through the string and
//   row memories while busy is high, until the last stored entry is
//   written; on an empty string busy stays low.
//   report (code 2) puts o_lcs_length and o_overflow out with o_strobe
//   for one cycle, in the cycle after the transfer, then clears the engine.
//   appends, reports and ignored codes leave busy low.
//   results cannot be held off; the strobe cycle is the transfer.
//   reset empties the string and the flag; the row needs no
//   clearing pass since each append zeroes its own entry.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lcs_length_engine_core
    import lcs_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [CMD_W-1:0] i_command,
    input  logic [SYM_W-1:0] i_symbol,
    output logic             o_strobe,
    output logic [LEN_W-1:0] o_lcs_length,
    output logic             o_overflow
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int DW = CW;
    localparam int XW = DW + LEN_W;

    typedef enum logic {
        S_IDLE,
        S_SWEEP
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_len;
    logic             r_ovf;
    logic [DW-1:0]    r_last;
    logic [SYM_W-1:0] r_sym;
    logic [CW-1:0]    r_rd_idx;
    logic             r_pend;
    logic [CW-1:0]    r_wr_idx;
    logic [DW-1:0]    r_above_old;
    logic [DW-1:0]    r_above_new;
    logic             r_strobe;
    logic [LEN_W-1:0] r_lcs_length;
    logic             r_overflow;

    logic             accept;
    logic             full;
    logic             can_issue;
    logic             last_wr;
    logic             match;
    logic [DW-1:0]    cell_next;
    logic [SYM_W-1:0] str_q;
    logic [DW-1:0]    dp_q;
    logic             str_we;
    logic             dp_we;
    logic [AW-1:0]    dp_waddr;
    logic [DW-1:0]    dp_wdata;
    logic [XW-1:0]    last_ext;
    logic [LEN_W-1:0] last_sat;
    logic             is_append;
    logic             is_sweep;
    logic             is_report;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign full   = (r_len == CW'(MAX_LEN));

    always_comb begin
        is_append = 1'b0;
        is_sweep  = 1'b0;
        is_report = 1'b0;
        unique case (i_command)
            CMD_APPEND: is_append = 1'b1;
            CMD_SWEEP:  is_sweep  = 1'b1;
            CMD_REPORT: is_report = 1'b1;
            default:    ;
        endcase
    end

    // dp cell: diagonal plus one on a match, else the larger neighbor
    assign match     = (str_q == r_sym);
    assign cell_next = match ? DW'(r_above_old + 1'b1)
                             : ((r_above_new > dp_q) ? r_above_new : dp_q);

    assign can_issue = (r_state == S_SWEEP) && (r_rd_idx < r_len);
    assign last_wr   = r_pend && (CW'(r_wr_idx + 1'b1) == r_len);

    assign str_we   = accept && is_append && !full;
    assign dp_we    = str_we || r_pend;
    assign dp_waddr = r_pend ? r_wr_idx[AW-1:0] : r_len[AW-1:0];
    assign dp_wdata = r_pend ? cell_next : '0;

    assign last_ext = XW'(r_last);
    assign last_sat = (last_ext > XW'(LEN_SAT)) ? LEN_SAT : last_ext[LEN_W-1:0];

    lcs_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_str_ram (
        .i_clk   (i_clk),
        .i_we    (str_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (i_symbol),
        .i_re    (can_issue),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (str_q)
    );

    lcs_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (dp_we),
        .i_waddr (dp_waddr),
        .i_wdata (dp_wdata),
        .i_re    (can_issue),
        .i_raddr (r_rd_idx[AW-1:0]),
        .o_rdata (dp_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && is_sweep && (r_len != '0)) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (!can_issue && (!r_pend || last_wr)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_last   <= '0;
            r_pend   <= 1'b0;
            r_rd_idx <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            r_pend   <= can_issue;
            if (can_issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
                r_wr_idx <= r_rd_idx;
            end
            if (r_pend) begin
                r_above_old <= dp_q;
                r_above_new <= cell_next;
                if (last_wr) begin
                    r_last <= cell_next;
                end
            end
            if (accept) begin
                if (is_append) begin
                    if (full) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_len  <= r_len + 1'b1;
                        r_last <= '0;
                    end
                end
                if (is_sweep) begin
                    r_sym       <= i_symbol;
                    r_rd_idx    <= '0;
                    r_above_old <= '0;
                    r_above_new <= '0;
                end
                if (is_report) begin
                    r_strobe     <= 1'b1;
                    r_lcs_length <= last_sat;
                    r_overflow   <= r_ovf;
                    r_len        <= '0;
                    r_ovf        <= 1'b0;
                    r_last       <= '0;
                end
            end
        end
    end

    assign o_strobe     = r_strobe;
    assign o_lcs_length = r_lcs_length;
    assign o_overflow   = r_overflow;

    `ASSERT_NEVER(a_len_range, i_clk, i_rst_n, r_len > CW'(MAX_LEN))
    `ASSERT_CLK(a_strobe_cause, i_clk, i_rst_n,
        o_strobe |-> $past(start && !busy && (i_command == CMD_REPORT)))
    `ASSERT_CLK(a_wr_in_string, i_clk, i_rst_n, r_pend |-> (r_wr_idx < r_len))
    `ASSERT_CLK(a_rd_bounded, i_clk, i_rst_n, busy |-> (r_rd_idx <= r_len))
    `ASSERT_CLK(a_len_held, i_clk, i_rst_n, busy |=> $stable(r_len))

endmodule

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lcs length engine core
// ----------------------------------------------------------------------------
// A queue of commands is built up front. It holds a few directed cases,
// full-store strings with dropped bytes, and random well-formed append,
// sweep and report sequences mixed with noise. A clocked driver presents the
// commands with random gaps. A clocked monitor feeds every command transfer to
// its own LCS row model. It checks each report strobe against the oldest
// predicted length and overflow flag.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lcs_pkg::*;

    localparam int STR_MAX        = MAX_LEN_DEF;
    localparam int IW             = $clog2(STR_MAX);
    localparam logic [CMD_W-1:0] CMD_IGNORED = 2'd3;
    localparam int TARGET_CMDS    = 1200;
    localparam int TARGET_REPORTS = 48;
    localparam int QUIET_TAIL     = 150;
    localparam int DRAIN_CYCLES   = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_SHOWN      = 10;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [SYM_W-1:0] sym;
    } t_lcs_cmd;

    typedef struct packed {
        logic [LEN_W-1:0] length;
        logic             ovf;
    } t_lcs_report;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [CMD_W-1:0] i_command = '0;
    logic [SYM_W-1:0] i_symbol = '0;
    logic             o_strobe;
    logic [LEN_W-1:0] o_lcs_length;
    logic             o_overflow;

    t_lcs_cmd    cmd_queue[$];
    t_lcs_report report_queue[$];

    // predictor state
    logic [SYM_W-1:0] first_bytes[STR_MAX];
    logic [LEN_W-1:0] row_len[STR_MAX];
    int               stored_len = 0;
    logic             dropped = 1'b0;

    int n_planned = 0;
    int n_reports_planned = 0;
    int n_accepted = 0;
    int n_ignored = 0;
    int n_checked = 0;
    int n_ovf_seen = 0;
    int max_len_seen = 0;
    int n_errors = 0;
    int idle_cycles = 0;

    lcs_length_engine_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_symbol    (i_symbol),
        .o_strobe    (o_strobe),
        .o_lcs_length(o_lcs_length),
        .o_overflow  (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    task automatic push_cmd(input logic [CMD_W-1:0] c, input logic [SYM_W-1:0] s);
        cmd_queue.push_back('{cmd: c, sym: s});
        if (c != CMD_IGNORED) begin
            n_planned++;
        end
        if (c == CMD_REPORT) begin
            n_reports_planned++;
        end
    endtask

    // one string filling the store plus dropped bytes; mirror gives the top length
    task automatic push_full_store(input bit mirror);
        logic [SYM_W-1:0] bytes[STR_MAX];
        logic [SYM_W-1:0] base;
        base = SYM_W'($urandom_range(0, 255));
        for (int k = 0; k < STR_MAX; k++) begin
            bytes[IW'(k)] = base ^ SYM_W'($urandom_range(0, 3));
            push_cmd(CMD_APPEND, bytes[IW'(k)]);
        end
        push_cmd(CMD_APPEND, SYM_W'($urandom_range(0, 255)));
        push_cmd(CMD_APPEND, SYM_W'($urandom_range(0, 255)));
        if (mirror) begin
            for (int k = 0; k < STR_MAX; k++) begin
                push_cmd(CMD_SWEEP, bytes[IW'(k)]);
            end
        end else begin
            for (int k = 0; k < 16; k++) begin
                push_cmd(CMD_SWEEP, base ^ SYM_W'($urandom_range(0, 3)));
            end
        end
        push_cmd(CMD_REPORT, SYM_W'($urandom_range(0, 255)));
    endtask

    function automatic logic [SYM_W-1:0] pick_sym(input logic [SYM_W-1:0] base,
                                                 input logic [SYM_W-1:0] mask);
        return base ^ (SYM_W'($urandom) & mask);
    endfunction

    task automatic push_random_sequence();
        int               n_first;
        int               n_second;
        logic [SYM_W-1:0] base;
        logic [SYM_W-1:0] mask;
        base = SYM_W'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: mask = 8'h01;
            1: mask = 8'h03;
            2: mask = 8'h0F;
            default: mask = 8'hFF;
        endcase
        if ($urandom_range(0, 9) == 0) begin
            // noise: any code, any byte, no closing report
            n_first = $urandom_range(1, 8);
            for (int k = 0; k < n_first; k++) begin
                push_cmd(CMD_W'($urandom_range(0, 3)), SYM_W'($urandom_range(0, 255)));
            end
        end else begin
            n_first = $urandom_range(0, 12);
            n_second = $urandom_range(0, 12);
            for (int k = 0; k < n_first; k++) begin
                push_cmd(CMD_APPEND, pick_sym(base, mask));
                if ($urandom_range(0, 19) == 0) begin
                    push_cmd(CMD_IGNORED, SYM_W'($urandom_range(0, 255)));
                end
            end
            for (int k = 0; k < n_second; k++) begin
                push_cmd(CMD_SWEEP, pick_sym(base, mask));
                if ($urandom_range(0, 9) == 0) begin
                    push_cmd(CMD_APPEND, pick_sym(base, mask));
                end
            end
            push_cmd(CMD_REPORT, SYM_W'($urandom_range(0, 255)));
            if ($urandom_range(0, 14) == 0) begin
                push_cmd(CMD_REPORT, SYM_W'($urandom_range(0, 255)));
            end
        end
    endtask

    // one row update per sweep byte, mirroring the engine's walk over the string; appends and reports update the store
    task automatic predict_command(input t_lcs_cmd item);
        logic [LEN_W-1:0] diag;
        logic [LEN_W-1:0] left_new;
        logic [LEN_W-1:0] old_v;
        t_lcs_report      rep;
        case (item.cmd)
            CMD_APPEND: begin
                if (stored_len < STR_MAX) begin
                    first_bytes[IW'(stored_len)] = item.sym;
                    row_len[IW'(stored_len)] = '0;
                    stored_len++;
                end else begin
                    dropped = 1'b1;
                end
            end
            CMD_SWEEP: begin
                diag = '0;
                left_new = '0;
                for (int k = 0; k < stored_len; k++) begin
                    old_v = row_len[IW'(k)];
                    if (first_bytes[IW'(k)] == item.sym) begin
                        row_len[IW'(k)] = diag + 1'b1;
                    end else if (left_new > old_v) begin
                        row_len[IW'(k)] = left_new;
                    end
                    diag = old_v;
                    left_new = row_len[IW'(k)];
                end
            end
            CMD_REPORT: begin
                rep.length = (stored_len > 0) ? row_len[IW'(stored_len - 1)] : '0;
                rep.ovf = dropped;
                report_queue.push_back(rep);
                stored_len = 0;
                dropped = 1'b0;
                for (int k = 0; k < STR_MAX; k++) begin
                    row_len[IW'(k)] = '0;
                end
            end
            default: begin
                n_ignored++;
            end
        endcase
    endtask

    task automatic flag_mismatch(input string what, input t_lcs_report want,
                                 input t_lcs_report got);
        n_errors++;
        if (n_errors <= MAX_SHOWN) begin
            $display("mismatch (%0s): expected length %0d overflow %0d,",
                     what, want.length, want.ovf);
            $display("    got length %0d overflow %0d", got.length, got.ovf);
        end
    endtask

    // driver: hold a command until transferred, random gap bursts between commands
    int gap_left = 0;
    int idle_on = 1;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) begin
                void'(cmd_queue.pop_front());
                if ((n_accepted % 64) == 0) begin
                    idle_on = $urandom_range(0, 2);
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (cmd_queue.size() == 0) begin
                start <= 1'b0;
            end else if (idle_on != 0 && cmd_queue.size() > QUIET_TAIL &&
                         $urandom_range(0, 3) == 0) begin
                gap_left = $urandom_range(0, 5);
                start <= 1'b0;
            end else begin
                start <= 1'b1;
                i_command <= cmd_queue[0].cmd;
                i_symbol <= cmd_queue[0].sym;
            end
        end
    end

    // monitor: predict on command transfer, check on report strobe
    always @(posedge i_clk) begin
        t_lcs_report got;
        t_lcs_report want;
        if (i_rst_n) begin
            if (start && !busy) begin
                predict_command('{cmd: i_command, sym: i_symbol});
                n_accepted++;
            end
            if (o_strobe) begin
                got.length = o_lcs_length;
                got.ovf = o_overflow;
                if (report_queue.size() == 0) begin
                    flag_mismatch("no report pending", '0, got);
                end else begin
                    want = report_queue.pop_front();
                    n_checked++;
                    if (want.ovf) begin
                        n_ovf_seen++;
                    end
                    if (int'(want.length) > max_len_seen) begin
                        max_len_seen = int'(want.length);
                    end
                    if (got.length !== want.length || got.ovf !== want.ovf) begin
                        flag_mismatch("report", want, got);
                    end
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial begin
        // empty strings, both ends of the byte range
        push_cmd(CMD_REPORT, 8'h00);
        push_cmd(CMD_APPEND, 8'h00);
        push_cmd(CMD_REPORT, 8'hFF);
        push_cmd(CMD_SWEEP, 8'hFF);
        push_cmd(CMD_REPORT, 8'h00);
        // crossed pair, ignored code in between
        push_cmd(CMD_APPEND, 8'hFF);
        push_cmd(CMD_APPEND, 8'h00);
        push_cmd(CMD_SWEEP, 8'h00);
        push_cmd(CMD_IGNORED, 8'hAA);
        push_cmd(CMD_SWEEP, 8'hFF);
        push_cmd(CMD_IGNORED, 8'h55);
        push_cmd(CMD_REPORT, 8'hFF);
        // byte appended after a sweep only sees later sweeps
        push_cmd(CMD_APPEND, 8'h55);
        push_cmd(CMD_SWEEP, 8'h55);
        push_cmd(CMD_APPEND, 8'h55);
        push_cmd(CMD_SWEEP, 8'h55);
        push_cmd(CMD_REPORT, 8'h00);
        push_cmd(CMD_REPORT, 8'h00);
        push_cmd(CMD_REPORT, 8'hFF);

        push_full_store(1'b1);
        push_full_store(1'b0);
        while (n_planned < TARGET_CMDS || n_reports_planned < TARGET_REPORTS) begin
            push_random_sequence();
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || start) begin
            @(posedge i_clk);
        end
        while (report_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        n_errors += report_queue.size();
        $display("covered %0d command transfers (%0d with unused codes), %0d reports checked",
                 n_accepted, n_ignored, n_checked);
        $display("longest length reported %0d, %0d reports with dropped bytes",
                 max_len_seen, n_ovf_seen);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/lcs_pkg.sv
rtl/lcs_ram.sv
rtl/lcs_length_engine_core.sv
bench/tb_top.sv
